>>> sv/yab_pkg.sv
// Shared types, constants and helper functions for the YUV alpha blend pipeline.
// No dependencies; every other source file but yab_checker refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package yab_pkg;

  // Fraction bits of the fixed-point color matrices.
  localparam int COEF_FRAC_BITS_DEF = 16;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ALPHA        = 2'd0;
  localparam logic [1:0] CFG_BLEND_TWO    = 2'd1;
  localparam logic [1:0] CFG_INTEGER_MODE = 2'd2;

  localparam logic [8:0] ALPHA_RESET   = 9'd128;
  localparam logic [8:0] ALPHA_FULL    = 9'd256;
  localparam logic       BLEND_RESET   = 1'b0;
  localparam logic       INTMODE_RESET = 1'b1;

  // Stream widths.
  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 24;

  // One 8-bit sample per color channel, index 0 is R (or Y), 1 is G (U), 2 is B (V).
  typedef logic [2:0][7:0] rgb_t;

  // Control shared by all pipeline sections.
  typedef struct packed {
    logic en;            // advance every stage
    logic integer_mode;  // 1: BT.601 integer matrices, 0: fixed-point matrices
  } pipe_ctl_t;

  // Real coefficient given in thousandths, scaled to Q(frac), rounded half up.
  function automatic longint q_coef(input int milli, input int frac);
    return (longint'(milli) * (longint'(1) << frac) + 64'sd500) / 64'sd1000;
  endfunction

  // Saturate a signed value to 0..255.
  function automatic logic [7:0] clip8(input logic signed [63:0] v);
    logic [7:0] r;
    if (v[63]) begin
      r = 8'd0;
    end else if (v > 64'sd255) begin
      r = 8'hFF;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/yab_to_rgb.sv
// Two-stage YUV to RGB conversion of one picture: constant products, then sum,
// floor shift and clamp. Depends on yab_pkg.
`timescale 1ns / 1ps
`default_nettype none

module yab_to_rgb #(
  parameter int COEF_FRAC_BITS = yab_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire                  clk_i,
  input  yab_pkg::pipe_ctl_t   ctl_i,
  input  wire  [7:0]           luma_i,
  input  wire  [7:0]           cb_i,
  input  wire  [7:0]           cr_i,
  output yab_pkg::rgb_t        rgb_o
);

  localparam int RW = COEF_FRAC_BITS + 11;

  localparam logic signed [RW-1:0] QR_E = RW'(yab_pkg::q_coef(1140, COEF_FRAC_BITS));
  localparam logic signed [RW-1:0] QG_D = RW'(-yab_pkg::q_coef(394, COEF_FRAC_BITS));
  localparam logic signed [RW-1:0] QG_E = RW'(-yab_pkg::q_coef(581, COEF_FRAC_BITS));
  localparam logic signed [RW-1:0] QB_D = RW'(yab_pkg::q_coef(2032, COEF_FRAC_BITS));

  localparam logic signed [RW-1:0] IC   = RW'(298);
  localparam logic signed [RW-1:0] IR_E = RW'(409);
  localparam logic signed [RW-1:0] IG_D = RW'(-100);
  localparam logic signed [RW-1:0] IG_E = RW'(-208);
  localparam logic signed [RW-1:0] IB_D = RW'(516);
  localparam logic signed [RW-1:0] IRND = RW'(128);

  logic signed [8:0]    c_s, d_s, e_s;
  logic signed [RW-1:0] c_w, d_w, e_w;
  logic signed [RW-1:0] base_d, r_e_d, g_d_d, g_e_d, b_d_d;
  logic signed [RW-1:0] base_q, r_e_q, g_d_q, g_e_q, b_d_q;
  logic signed [RW-1:0] sum_r, sum_g, sum_b;
  logic signed [RW-1:0] sh_r, sh_g, sh_b;
  yab_pkg::rgb_t        rgb_d, rgb_q;

  // Stage 1: offset removal (luma offset in integer mode only) and constant products.
  always_comb begin
    c_s = $signed({1'b0, luma_i}) - 9'sd16;
    d_s = $signed({1'b0, cb_i}) - 9'sd128;
    e_s = $signed({1'b0, cr_i}) - 9'sd128;
    c_w = RW'(c_s);
    d_w = RW'(d_s);
    e_w = RW'(e_s);
    if (ctl_i.integer_mode) begin
      base_d = c_w * IC + IRND;
      r_e_d  = e_w * IR_E;
      g_d_d  = d_w * IG_D;
      g_e_d  = e_w * IG_E;
      b_d_d  = d_w * IB_D;
    end else begin
      base_d = $signed(RW'({1'b0, luma_i})) <<< COEF_FRAC_BITS;
      r_e_d  = e_w * QR_E;
      g_d_d  = d_w * QG_D;
      g_e_d  = e_w * QG_E;
      b_d_d  = d_w * QB_D;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      base_q <= base_d;
      r_e_q  <= r_e_d;
      g_d_q  <= g_d_d;
      g_e_q  <= g_e_d;
      b_d_q  <= b_d_d;
    end
  end

  // Stage 2: sum, floor shift, clamp.
  always_comb begin
    sum_r = base_q + r_e_q;
    sum_g = base_q + g_d_q + g_e_q;
    sum_b = base_q + b_d_q;
    if (ctl_i.integer_mode) begin
      sh_r = sum_r >>> 8;
      sh_g = sum_g >>> 8;
      sh_b = sum_b >>> 8;
    end else begin
      sh_r = sum_r >>> COEF_FRAC_BITS;
      sh_g = sum_g >>> COEF_FRAC_BITS;
      sh_b = sum_b >>> COEF_FRAC_BITS;
    end
    rgb_d[0] = yab_pkg::clip8(64'(sh_r));
    rgb_d[1] = yab_pkg::clip8(64'(sh_g));
    rgb_d[2] = yab_pkg::clip8(64'(sh_b));
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      rgb_q <= rgb_d;
    end
  end

  assign rgb_o = rgb_q;

endmodule

`default_nettype wire

>>> sv/yab_mix.sv
// Two-stage alpha scale or blend of the RGB channels: weight products, then
// sum and divide by 256. Depends on yab_pkg.
`timescale 1ns / 1ps
`default_nettype none

module yab_mix (
  input  wire                  clk_i,
  input  yab_pkg::pipe_ctl_t   ctl_i,
  input  wire  [8:0]           weight_i,   // already saturated to 0..256
  input  wire                  blend_two_i,
  input  yab_pkg::rgb_t        rgb_a_i,
  input  yab_pkg::rgb_t        rgb_b_i,
  output yab_pkg::rgb_t        rgb_o
);

  logic [8:0]       weight_b;
  logic [2:0][15:0] pa_d, pb_d, pa_q, pb_q;
  logic [2:0][16:0] sum;
  yab_pkg::rgb_t    mix_d, mix_q;

  assign weight_b = yab_pkg::ALPHA_FULL - weight_i;

  // Stage 3: weight products; single mode drops picture B.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pa_d[k] = 16'(17'(rgb_a_i[k]) * 17'(weight_i));
      pb_d[k] = blend_two_i ? 16'(17'(rgb_b_i[k]) * 17'(weight_b)) : 16'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
    end
  end

  // Stage 4: the weighted sum never exceeds 255*256, so no clamp is needed.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k]   = 17'(pa_q[k]) + 17'(pb_q[k]);
      mix_d[k] = sum[k][15:8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      mix_q <= mix_d;
    end
  end

  assign rgb_o = mix_q;

endmodule

`default_nettype wire

>>> sv/yab_to_yuv.sv
// Two-stage RGB to YUV conversion: matrix products, then sum, floor shift,
// offset, clamp and chroma masking into the output register. Depends on yab_pkg.
`timescale 1ns / 1ps
`default_nettype none

module yab_to_yuv #(
  parameter int COEF_FRAC_BITS = yab_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire                  clk_i,
  input  yab_pkg::pipe_ctl_t   ctl_i,
  input  yab_pkg::rgb_t        rgb_i,
  input  wire                  site_i,
  output yab_pkg::rgb_t        yuv_o,
  output logic                 chroma_valid_o
);

  localparam int RW = COEF_FRAC_BITS + 11;
  localparam int F  = COEF_FRAC_BITS;

  localparam logic signed [RW-1:0] COEF_INT [3][3] = '{
    '{RW'(66),  RW'(129), RW'(25)},
    '{RW'(-38), RW'(-74), RW'(112)},
    '{RW'(112), RW'(-94), RW'(-18)}
  };

  localparam logic signed [RW-1:0] COEF_FIX [3][3] = '{
    '{RW'(yab_pkg::q_coef(299, F)),  RW'(yab_pkg::q_coef(587, F)),
      RW'(yab_pkg::q_coef(114, F))},
    '{RW'(-yab_pkg::q_coef(147, F)), RW'(-yab_pkg::q_coef(289, F)),
      RW'(yab_pkg::q_coef(436, F))},
    '{RW'(yab_pkg::q_coef(615, F)),  RW'(-yab_pkg::q_coef(515, F)),
      RW'(-yab_pkg::q_coef(100, F))}
  };

  localparam logic signed [RW-1:0] OFS_INT [3] = '{RW'(16), RW'(128), RW'(128)};
  localparam logic signed [RW-1:0] OFS_FIX [3] = '{RW'(0), RW'(128), RW'(128)};
  localparam logic signed [RW-1:0] IRND = RW'(128);

  logic signed [RW-1:0] prod_d [3][3];
  logic signed [RW-1:0] prod_q [3][3];
  logic signed [RW-1:0] sum    [3];
  logic signed [RW-1:0] res    [3];
  logic                 site_q;
  yab_pkg::rgb_t        yuv_d, yuv_q;
  logic                 cv_q;

  // Stage 5: nine constant products.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        prod_d[j][k] = $signed(RW'({1'b0, rgb_i[k]}))
                     * (ctl_i.integer_mode ? COEF_INT[j][k] : COEF_FIX[j][k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      prod_q <= prod_d;
      site_q <= site_i;
    end
  end

  // Stage 6: sum, floor shift, offset, clamp; zero the chroma off its sites.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sum[j] = prod_q[j][0] + prod_q[j][1] + prod_q[j][2];
      if (ctl_i.integer_mode) begin
        res[j] = ((sum[j] + IRND) >>> 8) + OFS_INT[j];
      end else begin
        res[j] = (sum[j] >>> COEF_FRAC_BITS) + OFS_FIX[j];
      end
      yuv_d[j] = yab_pkg::clip8(64'(res[j]));
    end
    if (!site_q) begin
      yuv_d[1] = 8'd0;
      yuv_d[2] = 8'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      yuv_q <= yuv_d;
      cv_q  <= site_q;
    end
  end

  assign yuv_o          = yuv_q;
  assign chroma_valid_o = cv_q;

endmodule

`default_nettype wire

>>> sv/yuv_alpha_blend_pixel.sv
// Throughput: one pixel per cycle while the output is not stalled; six register stages
// (two RGB conversion, two blend, two YUV conversion) advance together, with a one-beat
// input skid buffer. Reset (rst_ni low, asynchronous) empties the pipeline and skid
// buffer and loads alpha=128, blend_two=0, integer_mode=1. Depends on yab_pkg and the
// yab_* modules.
`timescale 1ns / 1ps
`default_nettype none

module yuv_alpha_blend_pixel #(
  parameter int COEF_FRAC_BITS = yab_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // config write port
  input  wire                          cfg_we_i,
  input  wire  [1:0]                   cfg_index_i,
  input  wire  [8:0]                   cfg_wdata_i,
  // pixel input
  input  wire                          s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // luma_a, cb_a, cr_a, luma_b, cb_b, cr_b
  input  wire  [yab_pkg::S_DATA_W-1:0] s_axis_tdata_i,
  // chroma_site
  input  wire                          s_axis_tuser_i,
  // pixel output
  output logic                         m_axis_tvalid_o,
  input  wire                          m_axis_tready_i,
  // luma_out, cb_out, cr_out
  output logic [yab_pkg::M_DATA_W-1:0] m_axis_tdata_o,
  // chroma_valid
  output logic                         m_axis_tuser_o
);

  localparam int STAGES = 6;

  logic [8:0]                   alpha_q;
  logic                         blend_q, intmode_q;
  logic [8:0]                   weight;

  logic                         skid_valid_q, skid_valid_d;
  logic [yab_pkg::S_DATA_W-1:0] skid_data_q;
  logic                         skid_site_q;
  logic                         in_valid;
  logic [yab_pkg::S_DATA_W-1:0] in_data;
  logic                         in_site;

  logic [STAGES-1:0]            v_q;
  logic [STAGES-3:0]            site_q;
  yab_pkg::pipe_ctl_t           ctl;
  yab_pkg::rgb_t                rgb_a, rgb_b, rgb_m, yuv;
  logic                         chroma_valid;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q   <= yab_pkg::ALPHA_RESET;
      blend_q   <= yab_pkg::BLEND_RESET;
      intmode_q <= yab_pkg::INTMODE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        yab_pkg::CFG_ALPHA:        alpha_q   <= cfg_wdata_i;
        yab_pkg::CFG_BLEND_TWO:    blend_q   <= cfg_wdata_i[0];
        yab_pkg::CFG_INTEGER_MODE: intmode_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign weight = (alpha_q > yab_pkg::ALPHA_FULL) ? yab_pkg::ALPHA_FULL : alpha_q;

  // Whole pipeline advances unless the output beat is stalled.
  assign ctl.en           = !v_q[STAGES-1] || m_axis_tready_i;
  assign ctl.integer_mode = intmode_q;

  // Skid buffer: hold a beat taken while the pipeline stalls.
  assign s_axis_tready_o = !skid_valid_q;
  assign in_valid        = skid_valid_q || s_axis_tvalid_i;
  assign in_data         = skid_valid_q ? skid_data_q : s_axis_tdata_i;
  assign in_site         = skid_valid_q ? skid_site_q : s_axis_tuser_i;

  always_comb begin
    skid_valid_d = skid_valid_q;
    if (ctl.en) begin
      skid_valid_d = 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else begin
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ctl.en && s_axis_tvalid_i && s_axis_tready_o) begin
      skid_data_q <= s_axis_tdata_i;
      skid_site_q <= s_axis_tuser_i;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (ctl.en) begin
      v_q <= {v_q[STAGES-2:0], in_valid};
    end
  end

  // Carry the chroma site alongside the blended RGB; the YUV stage takes it from there.
  always_ff @(posedge clk_i) begin
    if (ctl.en) begin
      site_q <= {site_q[STAGES-4:0], in_site};
    end
  end

  yab_to_rgb #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_rgb_a (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .luma_i (in_data[7:0]),
    .cb_i   (in_data[15:8]),
    .cr_i   (in_data[23:16]),
    .rgb_o  (rgb_a)
  );

  yab_to_rgb #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_rgb_b (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .luma_i (in_data[31:24]),
    .cb_i   (in_data[39:32]),
    .cr_i   (in_data[47:40]),
    .rgb_o  (rgb_b)
  );

  yab_mix u_mix (
    .clk_i       (clk_i),
    .ctl_i       (ctl),
    .weight_i    (weight),
    .blend_two_i (blend_q),
    .rgb_a_i     (rgb_a),
    .rgb_b_i     (rgb_b),
    .rgb_o       (rgb_m)
  );

  yab_to_yuv #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_yuv (
    .clk_i          (clk_i),
    .ctl_i          (ctl),
    .rgb_i          (rgb_m),
    .site_i         (site_q[STAGES-3]),
    .yuv_o          (yuv),
    .chroma_valid_o (chroma_valid)
  );

  assign m_axis_tvalid_o = v_q[STAGES-1];
  assign m_axis_tdata_o  = {yuv[2], yuv[1], yuv[0]};
  assign m_axis_tuser_o  = chroma_valid;

endmodule

`default_nettype wire

>>> sv/yab_checker.sv
// Port-level checks for yuv_alpha_blend_pixel, attached by bind.
// Sees only the top-level ports; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module yab_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid_i,
  input wire        s_axis_tready_o,
  input wire        m_axis_tvalid_o,
  input wire        m_axis_tready_i,
  input wire [23:0] m_axis_tdata_o,
  input wire        m_axis_tuser_o
);

  // No output beat offered in the cycle after reset is seen low.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("output valid during reset");

  // A stalled output beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o))
    else $error("stalled output beat changed");

  // Chroma off its sites reads as zero.
  a_chroma_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o[23:8] == 16'd0)
    else $error("chroma not zero off a chroma site");

  // Input ready drops only after a beat was taken into the skid buffer.
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o && m_axis_tvalid_o
      && !m_axis_tready_i))
    else $error("input ready dropped without a stalled accept");

endmodule

bind yuv_alpha_blend_pixel yab_checker u_yab_checker (.*);

`default_nettype wire

>>> bench/tb.sv
// Self-checking bench for yuv_alpha_blend_pixel: drives YUV pixel pairs over the input stream,
// predicts every output beat in-bench and compares it with what the block sends back.
// Depends on yab_pkg and the yuv_alpha_blend_pixel RTL.
`timescale 1ns / 1ps

module tb;

  localparam int FRAC          = yab_pkg::COEF_FRAC_BITS_DEF;
  localparam int LATENCY       = 6;
  localparam int RANDOM_PIXELS = 1550;
  localparam int MAX_REPORTS   = 30;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam logic [7:0] LUMA_EDGES [4] = '{8'd0, 8'd16, 8'd235, 8'd255};

  typedef struct packed {
    logic [7:0] luma_a, cb_a, cr_a;
    logic [7:0] luma_b, cb_b, cr_b;
    logic       site;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] luma, cb, cr;
    logic       chroma_valid;
  } pixel_out_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_e;

  // Real coefficient in thousandths as a signed Q(FRAC) value, nearest, half away from zero.
  function automatic longint fixed_coef(input int milli);
    longint one;
    one = longint'(1) << FRAC;
    return (longint'(milli) * one + 64'sd500) / 64'sd1000;
  endfunction

  localparam longint K_RV = fixed_coef(1140);
  localparam longint K_GU = -fixed_coef(394);
  localparam longint K_GV = -fixed_coef(581);
  localparam longint K_BU = fixed_coef(2032);
  localparam longint K_YR = fixed_coef(299);
  localparam longint K_YG = fixed_coef(587);
  localparam longint K_YB = fixed_coef(114);
  localparam longint K_UR = -fixed_coef(147);
  localparam longint K_UG = -fixed_coef(289);
  localparam longint K_UB = fixed_coef(436);
  localparam longint K_VR = fixed_coef(615);
  localparam longint K_VG = -fixed_coef(515);
  localparam longint K_VB = -fixed_coef(100);

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [8:0]  cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic [47:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tready = 1'b0;
  wire         s_axis_tready_o;
  wire         m_axis_tvalid_o;
  wire  [23:0] m_axis_tdata_o;
  wire         m_axis_tuser_o;

  // Shadow of the block's registers, changed only while the pipeline is empty.
  logic [8:0]  cfg_alpha = yab_pkg::ALPHA_RESET;
  logic        cfg_blend = yab_pkg::BLEND_RESET;
  logic        cfg_int   = yab_pkg::INTMODE_RESET;

  pixel_out_t  blended_due [$];
  int          mismatches = 0;
  int          burst_left = 0;
  rx_mode_e    rx_mode = RX_OPEN;
  int          rx_left = 0;
  int          rx_phase = 0;
  pixel_out_t  want, got;

  yuv_alpha_blend_pixel dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    // luma_a, cb_a, cr_a, luma_b, cb_b, cr_b
    .s_axis_tdata_i  (s_tdata),
    // chroma_site
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    // luma_out, cb_out, cr_out
    .m_axis_tdata_o  (m_axis_tdata_o),
    // chroma_valid
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

  function automatic logic [7:0] sat8(input longint v);
    if (v < 0) begin
      return 8'd0;
    end else if (v > 255) begin
      return 8'd255;
    end
    return v[7:0];
  endfunction

  function automatic yab_pkg::rgb_t yuv_to_rgb(input logic [7:0] y, u, v);
    longint c, d, e;
    yab_pkg::rgb_t px;
    d = longint'(u) - 128;
    e = longint'(v) - 128;
    if (cfg_int) begin
      c = 298 * (longint'(y) - 16);
      px[0] = sat8((c + 409 * e + 128) >>> 8);
      px[1] = sat8((c - 100 * d - 208 * e + 128) >>> 8);
      px[2] = sat8((c + 516 * d + 128) >>> 8);
    end else begin
      c = longint'(y) <<< FRAC;
      px[0] = sat8((c + K_RV * e) >>> FRAC);
      px[1] = sat8((c + K_GU * d + K_GV * e) >>> FRAC);
      px[2] = sat8((c + K_BU * d) >>> FRAC);
    end
    return px;
  endfunction

  // Expected output beat for one input pixel under the current register settings.
  function automatic pixel_out_t blend_pixel(input pixel_in_t p);
    yab_pkg::rgb_t ra, rb, mix;
    longint w, mr, mg, mb, y, u, v;
    pixel_out_t r;
    w  = (cfg_alpha > 9'd256) ? 256 : longint'(cfg_alpha);
    ra = yuv_to_rgb(p.luma_a, p.cb_a, p.cr_a);
    rb = yuv_to_rgb(p.luma_b, p.cb_b, p.cr_b);
    for (int k = 0; k < 3; k++) begin
      if (cfg_blend) begin
        mix[k] = sat8((longint'(ra[k]) * w + longint'(rb[k]) * (256 - w)) >>> 8);
      end else begin
        mix[k] = sat8((longint'(ra[k]) * w) >>> 8);
      end
    end
    mr = longint'(mix[0]);
    mg = longint'(mix[1]);
    mb = longint'(mix[2]);
    if (cfg_int) begin
      y = ((66 * mr + 129 * mg + 25 * mb + 128) >>> 8) + 16;
      u = ((-38 * mr - 74 * mg + 112 * mb + 128) >>> 8) + 128;
      v = ((112 * mr - 94 * mg - 18 * mb + 128) >>> 8) + 128;
    end else begin
      y = (K_YR * mr + K_YG * mg + K_YB * mb) >>> FRAC;
      u = ((K_UR * mr + K_UG * mg + K_UB * mb) >>> FRAC) + 128;
      v = ((K_VR * mr + K_VG * mg + K_VB * mb) >>> FRAC) + 128;
    end
    r.luma         = sat8(y);
    r.cb           = p.site ? sat8(u) : 8'd0;
    r.cr           = p.site ? sat8(v) : 8'd0;
    r.chroma_valid = p.site;
    return r;
  endfunction

  function automatic pixel_in_t mk_px(input logic [7:0] la, ua, va, lb, ub, vb,
                                      input logic site);
    pixel_in_t p;
    p = '{la, ua, va, lb, ub, vb, site};
    return p;
  endfunction

  function automatic pixel_in_t rand_pixel();
    pixel_in_t p;
    int flavor;
    flavor   = $urandom_range(0, 9);
    p.luma_a = 8'($urandom);
    p.cb_a   = 8'($urandom);
    p.cr_a   = 8'($urandom);
    p.luma_b = 8'($urandom);
    p.cb_b   = 8'($urandom);
    p.cr_b   = 8'($urandom);
    p.site   = 1'($urandom);
    if (flavor >= 5 && flavor <= 7) begin
      // keep chroma near neutral so the RGB stage clips less often
      p.cb_a = 8'($urandom_range(88, 168));
      p.cr_a = 8'($urandom_range(88, 168));
      p.cb_b = 8'($urandom_range(88, 168));
      p.cr_b = 8'($urandom_range(88, 168));
    end else if (flavor >= 8) begin
      p.luma_a = LUMA_EDGES[$urandom_range(0, 3)];
      p.luma_b = LUMA_EDGES[$urandom_range(0, 3)];
    end
    return p;
  endfunction

  // Queue the expectation as the beat is presented, then hold it until accepted.
  task automatic send_pixel(input pixel_in_t p);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 7);
      end
    end
    burst_left--;
    @(negedge clk_i);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {p.cr_b, p.cb_b, p.luma_b, p.cr_a, p.cb_a, p.luma_a};
    s_tuser  <= p.site;
    blended_due.push_back(blend_pixel(p));
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic settle_pipeline();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (blended_due.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [8:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      yab_pkg::CFG_ALPHA:        cfg_alpha = data;
      yab_pkg::CFG_BLEND_TWO:    cfg_blend = data[0];
      yab_pkg::CFG_INTEGER_MODE: cfg_int   = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Drain, then load all three registers; the one-bit ones get junk in the upper bits.
  task automatic apply_settings(input logic [8:0] alpha, input logic blend, input logic intm);
    settle_pipeline();
    write_reg(yab_pkg::CFG_ALPHA, alpha);
    write_reg(yab_pkg::CFG_BLEND_TWO, {8'($urandom), blend});
    write_reg(yab_pkg::CFG_INTEGER_MODE, {8'($urandom), intm});
  endtask

  task automatic test_reset_config();
    send_pixel(mk_px(8'd16, 8'd128, 8'd128, 8'd0, 8'd0, 8'd0, 1'b1));
    send_pixel(mk_px(8'd235, 8'd128, 8'd128, 8'd255, 8'd255, 8'd255, 1'b0));
    send_pixel(mk_px(8'd128, 8'd90, 8'd200, 8'd7, 8'd250, 8'd3, 1'b1));
  endtask

  task automatic test_color_extremes();
    apply_settings(9'd256, 1'b0, 1'b1);
    send_pixel(mk_px(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
    send_pixel(mk_px(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
    send_pixel(mk_px(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 1'b1));
    send_pixel(mk_px(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 1'b0));
    apply_settings(9'd256, 1'b1, 1'b0);
    send_pixel(mk_px(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 1'b1));
    send_pixel(mk_px(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1));
    apply_settings(9'd0, 1'b1, 1'b0);
    send_pixel(mk_px(8'd255, 8'd255, 8'd255, 8'd16, 8'd128, 8'd128, 1'b1));
    send_pixel(mk_px(8'd16, 8'd128, 8'd128, 8'd235, 8'd20, 8'd230, 1'b1));
  endtask

  // Alpha above 256 must behave as a full weight on picture A.
  task automatic test_alpha_limits();
    logic [8:0] alphas [4];
    alphas = '{9'd1, 9'd255, 9'd257, 9'd511};
    foreach (alphas[i]) begin
      apply_settings(alphas[i], 1'b1, 1'b1);
      send_pixel(mk_px(8'd200, 8'd60, 8'd180, 8'd40, 8'd190, 8'd70, 1'b1));
    end
    apply_settings(9'd0, 1'b0, 1'b1);
    send_pixel(mk_px(8'd255, 8'd255, 8'd0, 8'd9, 8'd9, 8'd9, 1'b1));
  endtask

  task automatic test_register_writes();
    settle_pipeline();
    write_reg(CFG_UNUSED, 9'h1FF);
    write_reg(yab_pkg::CFG_BLEND_TWO, 9'h1FE);
    write_reg(yab_pkg::CFG_INTEGER_MODE, 9'h0FF);
    write_reg(yab_pkg::CFG_ALPHA, 9'h0AA);
    send_pixel(mk_px(8'd100, 8'd150, 8'd110, 8'd1, 8'd2, 8'd3, 1'b1));
    send_pixel(mk_px(8'd180, 8'd30, 8'd220, 8'd4, 8'd5, 8'd6, 1'b0));
  endtask

  task automatic test_random_pixels();
    int sent, phase, burst;
    logic [8:0] alpha;
    logic blend, intm;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_PIXELS) begin
      if (phase < 12) begin
        // corners first: alpha 0, full and saturated in every mode pair
        case (phase % 3)
          0:       alpha = 9'd0;
          1:       alpha = 9'd256;
          default: alpha = 9'd511;
        endcase
        blend = 1'((phase / 3) % 2);
        intm  = 1'((phase / 6) % 2);
      end else begin
        alpha = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(256, 511))
                                            : 9'($urandom_range(0, 256));
        blend = 1'($urandom);
        intm  = 1'($urandom);
      end
      apply_settings(alpha, blend, intm);
      burst = $urandom_range(20, 110);
      for (int i = 0; i < burst && sent < RANDOM_PIXELS; i++) begin
        send_pixel(rand_pixel());
        sent++;
      end
      phase++;
    end
  endtask

  // Receiver backpressure: switch among a few stall patterns every so often.
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(32, 256);
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      RX_OPEN:   m_tready <= 1'b1;
      RX_COIN:   m_tready <= 1'($urandom);
      RX_SPARSE: m_tready <= (rx_phase % 5 == 0);
      default:   m_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      got = '{m_axis_tdata_o[7:0], m_axis_tdata_o[15:8], m_axis_tdata_o[23:16],
              m_axis_tuser_o};
      if (blended_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: unexpected beat luma=%0d cb=%0d cr=%0d cv=%0b",
                   $time, got.luma, got.cb, got.cr, got.chroma_valid);
        end
      end else begin
        want = blended_due.pop_front();
        if (got.luma !== want.luma || got.cb !== want.cb || got.cr !== want.cr ||
            got.chroma_valid !== want.chroma_valid) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: exp luma=%0d cb=%0d cr=%0d cv=%0b got luma=%0d cb=%0d cr=%0d cv=%0b",
                     $time, want.luma, want.cb, want.cr, want.chroma_valid,
                     got.luma, got.cb, got.cr, got.chroma_valid);
          end
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_config();
    test_color_extremes();
    test_alpha_limits();
    test_register_writes();
    test_random_pixels();
    settle_pipeline();
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/yab_pkg.sv
sv/yab_to_rgb.sv
sv/yab_mix.sv
sv/yab_to_yuv.sv
sv/yuv_alpha_blend_pixel.sv
sv/yab_checker.sv
bench/tb.sv
